// File: src/altitude_hold_pid_throttle_defines.svh
`ifndef ALTITUDE_HOLD_PID_THROTTLE_DEFINES_SVH
`define ALTITUDE_HOLD_PID_THROTTLE_DEFINES_SVH

// same-cycle implication, checked on clk_i, off while in reset
`define AHP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ahp check failed");

// next-cycle implication, checked on clk_i, off while in reset
`define AHP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ahp check failed");

`endif

// File: src/ahp_pkg.sv
`timescale 1ns / 1ps

package ahp_pkg;

  // pulse widths in microseconds
  localparam logic [10:0] PwLow  = 11'd1000;
  localparam logic [10:0] PwHigh = 11'd2000;

  // throttle bounds in units of 2^-18 us
  localparam int ThrW = 44;
  localparam logic signed [ThrW-1:0] ThrLow  = 44'sd262144000;
  localparam logic signed [ThrW-1:0] ThrHigh = 44'sd524288000;

  // shared multiplier operand widths
  localparam int MulAW  = 33;
  localparam int MulBW  = 25;
  localparam int ProdW  = MulAW + MulBW;

  // configuration port
  localparam int CfgIdxW  = 4;
  localparam int CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] RegArmDelay     = 4'd0;
  localparam logic [CfgIdxW-1:0] RegTargetHeight = 4'd1;
  localparam logic [CfgIdxW-1:0] RegRampRate     = 4'd2;
  localparam logic [CfgIdxW-1:0] RegHoverThrottle = 4'd3;
  localparam logic [CfgIdxW-1:0] RegGainP        = 4'd4;
  localparam logic [CfgIdxW-1:0] RegGainI        = 4'd5;
  localparam logic [CfgIdxW-1:0] RegGainD        = 4'd6;
  localparam logic [CfgIdxW-1:0] RegIntegralLimit = 4'd7;

  // register reset values
  localparam logic [31:0] RstArmDelay      = 32'd65536;
  localparam logic [22:0] RstTargetHeight  = 23'd2048;
  localparam logic [19:0] RstRampRate      = 20'd1024;
  localparam logic [10:0] RstHoverThrottle = 11'd1500;
  localparam logic [15:0] RstGainP         = 16'd25600;
  localparam logic [15:0] RstGainI         = 16'd5120;
  localparam logic [15:0] RstGainD         = 16'd12800;
  localparam logic [9:0]  RstIntegralLimit = 10'd200;

  // input command codes
  localparam logic CmdRestart = 1'b0;
  localparam logic CmdStep    = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [47:0] now_time;
    logic signed [23:0] height;
    logic signed [19:0] climb_speed;
    logic        is_armed;
    logic [15:0] step_time;
  } in_item_t;

  typedef struct packed {
    logic [10:0] throttle_us;
    logic [10:0] arm_us;
  } out_item_t;

  typedef struct packed {
    logic [31:0] arm_delay;
    logic [22:0] target_height;
    logic [19:0] ramp_rate;
    logic [10:0] hover_throttle;
    logic [15:0] gain_p;
    logic [15:0] gain_i;
    logic [15:0] gain_d;
    logic [9:0]  integral_limit;
  } cfg_t;

endpackage

// File: src/ahp_ifs.sv
`timescale 1ns / 1ps

// input item channel
interface ahp_in_if;
  logic               valid;
  logic               ready;
  ahp_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// result item channel
interface ahp_out_if;
  logic               valid;
  logic               ready;
  ahp_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// configuration write channel
interface ahp_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ahp_pkg::CfgIdxW-1:0]    index;
  logic [ahp_pkg::CfgDataW-1:0]   wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

// File: src/ahp_cfg_regs.sv
`timescale 1ns / 1ps

module ahp_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic [ahp_pkg::CfgIdxW-1:0]   wr_index_i,
  input  logic [ahp_pkg::CfgDataW-1:0]  wr_data_i,
  output ahp_pkg::cfg_t                 cfg_o
);

  ahp_pkg::cfg_t cfg_q;

  // register file, writes past the last index are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.arm_delay      <= ahp_pkg::RstArmDelay;
      cfg_q.target_height  <= ahp_pkg::RstTargetHeight;
      cfg_q.ramp_rate      <= ahp_pkg::RstRampRate;
      cfg_q.hover_throttle <= ahp_pkg::RstHoverThrottle;
      cfg_q.gain_p         <= ahp_pkg::RstGainP;
      cfg_q.gain_i         <= ahp_pkg::RstGainI;
      cfg_q.gain_d         <= ahp_pkg::RstGainD;
      cfg_q.integral_limit <= ahp_pkg::RstIntegralLimit;
    end else if (wr_en_i) begin
      unique case (wr_index_i)
        ahp_pkg::RegArmDelay:      cfg_q.arm_delay      <= wr_data_i;
        ahp_pkg::RegTargetHeight:  cfg_q.target_height  <= wr_data_i[22:0];
        ahp_pkg::RegRampRate:      cfg_q.ramp_rate      <= wr_data_i[19:0];
        ahp_pkg::RegHoverThrottle: cfg_q.hover_throttle <= wr_data_i[10:0];
        ahp_pkg::RegGainP:         cfg_q.gain_p         <= wr_data_i[15:0];
        ahp_pkg::RegGainI:         cfg_q.gain_i         <= wr_data_i[15:0];
        ahp_pkg::RegGainD:         cfg_q.gain_d         <= wr_data_i[15:0];
        ahp_pkg::RegIntegralLimit: cfg_q.integral_limit <= wr_data_i[9:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: src/ahp_mul.sv
`timescale 1ns / 1ps

module ahp_mul (
  input  logic                              clk_i,
  input  logic signed [ahp_pkg::MulAW-1:0]  op_a_i,
  input  logic signed [ahp_pkg::MulBW-1:0]  op_b_i,
  output logic signed [ahp_pkg::ProdW-1:0]  prod_o
);

  logic signed [ahp_pkg::ProdW-1:0] prod_d, prod_q;

  // signed product, registered
  assign prod_d = ahp_pkg::ProdW'(op_a_i) * ahp_pkg::ProdW'(op_b_i);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

// File: src/ahp_core.sv
`timescale 1ns / 1ps

module ahp_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ahp_pkg::cfg_t       cfg_i,
  input  logic                in_valid_i,
  input  ahp_pkg::in_item_t   in_data_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  output ahp_pkg::out_item_t  out_data_o,
  input  logic                out_ready_i
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RAMP  = 3'd1;
  localparam logic [2:0] S_IGAIN = 3'd2;
  localparam logic [2:0] S_IERR  = 3'd3;
  localparam logic [2:0] S_PGAIN = 3'd4;
  localparam logic [2:0] S_DGAIN = 3'd5;
  localparam logic [2:0] S_SUM   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  localparam int ThrW = ahp_pkg::ThrW;

  logic [2:0] state_q, state_d;

  // controller state
  logic [47:0]        start_time_q;
  logic [22:0]        setpoint_q;
  logic signed [26:0] integral_q;

  // per-item registers
  logic [15:0]             dt_q;
  logic signed [23:0]      height_q;
  logic signed [19:0]      climb_q;
  logic                    arm_hi_q;
  logic                    force_low_q;
  logic signed [24:0]      err_q;
  logic signed [ThrW-1:0]  thr_q;

  logic                     out_valid_q;
  ahp_pkg::out_item_t       out_data_q;

  logic signed [ahp_pkg::MulAW-1:0] op_a;
  logic signed [ahp_pkg::MulBW-1:0] op_b;
  logic signed [ahp_pkg::ProdW-1:0] prod;

  logic        in_fire;
  logic [47:0] elapsed;
  logic        arm_hi;
  logic [23:0] sp_sum;
  logic [22:0] sp_new;
  logic signed [24:0] err_new;
  logic signed [39:0] i_inc;
  logic signed [40:0] acc_sum;
  logic signed [40:0] acc_lim;
  logic signed [26:0] acc_new;
  logic signed [ThrW-1:0] thr_clamped;
  logic        out_free;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // arm channel: elapsed time since restart against the delay, no wrap
  assign elapsed = in_data_i.now_time - start_time_q;
  assign arm_hi  = (in_data_i.now_time >= start_time_q) &&
                   (elapsed >= {16'd0, cfg_i.arm_delay});

  // setpoint ramp from the registered ramp_rate * dt product
  assign sp_sum  = {1'b0, setpoint_q} + {4'd0, prod[35:16]};
  assign sp_new  = (sp_sum > {1'b0, cfg_i.target_height}) ? cfg_i.target_height
                                                           : sp_sum[22:0];
  assign err_new = $signed({2'b00, sp_new}) - 25'(height_q);

  // integral: floor of product by 2^18, then clamp
  assign i_inc   = 40'(prod >>> 18);
  assign acc_sum = 41'(integral_q) + 41'(i_inc);
  assign acc_lim = $signed({15'd0, cfg_i.integral_limit, 16'd0});
  always_comb begin
    priority if (acc_sum > acc_lim) begin
      acc_new = acc_lim[26:0];
    end else if (acc_sum < -acc_lim) begin
      acc_new = 27'(-acc_lim);
    end else begin
      acc_new = acc_sum[26:0];
    end
  end

  // final throttle clamp
  always_comb begin
    priority if (thr_q < ahp_pkg::ThrLow) begin
      thr_clamped = ahp_pkg::ThrLow;
    end else if (thr_q > ahp_pkg::ThrHigh) begin
      thr_clamped = ahp_pkg::ThrHigh;
    end else begin
      thr_clamped = thr_q;
    end
  end

  // multiplier operand select per step
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state_q)
      S_RAMP: begin
        op_a = ahp_pkg::MulAW'(cfg_i.ramp_rate);
        op_b = ahp_pkg::MulBW'(dt_q);
      end
      S_IGAIN: begin
        op_a = ahp_pkg::MulAW'(cfg_i.gain_i);
        op_b = ahp_pkg::MulBW'(dt_q);
      end
      S_IERR: begin
        op_a = $signed({1'b0, prod[31:0]});
        op_b = err_q;
      end
      S_PGAIN: begin
        op_a = ahp_pkg::MulAW'(cfg_i.gain_p);
        op_b = err_q;
      end
      S_DGAIN: begin
        op_a = ahp_pkg::MulAW'(cfg_i.gain_d);
        op_b = ahp_pkg::MulBW'(climb_q);
      end
      default: ;
    endcase
  end

  ahp_mul u_mul (
    .clk_i  (clk_i),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .prod_o (prod)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire && (in_data_i.cmd == ahp_pkg::CmdStep)) begin
          state_d = in_data_i.is_armed ? S_RAMP : S_DONE;
        end
      end
      S_RAMP:  state_d = S_IGAIN;
      S_IGAIN: state_d = S_IERR;
      S_IERR:  state_d = S_PGAIN;
      S_PGAIN: state_d = S_DGAIN;
      S_DGAIN: state_d = S_SUM;
      S_SUM:   state_d = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      start_time_q <= '0;
      setpoint_q   <= '0;
      integral_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      // restart records the start time and clears setpoint and integral
      if (in_fire && (in_data_i.cmd == ahp_pkg::CmdRestart)) begin
        start_time_q <= in_data_i.now_time;
        setpoint_q   <= '0;
        integral_q   <= '0;
      end
      if (state_q == S_IGAIN) begin
        setpoint_q <= sp_new;
      end
      if (state_q == S_PGAIN) begin
        integral_q <= acc_new;
      end
      // result register
      if ((state_q == S_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // per-item datapath registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      dt_q        <= in_data_i.step_time;
      height_q    <= in_data_i.height;
      climb_q     <= in_data_i.climb_speed;
      arm_hi_q    <= arm_hi;
      force_low_q <= !in_data_i.is_armed;
      thr_q       <= $signed({15'd0, cfg_i.hover_throttle, 18'd0});
    end
    if (state_q == S_IGAIN) begin
      err_q <= err_new;
    end
    if (state_q == S_DGAIN) begin
      thr_q <= thr_q + $signed(prod[ThrW-1:0]) + (ThrW'(integral_q) <<< 2);
    end
    if (state_q == S_SUM) begin
      thr_q <= thr_q - prod[ThrW-1:0];
    end
    if ((state_q == S_DONE) && out_free) begin
      out_data_q.throttle_us <= force_low_q ? ahp_pkg::PwLow : thr_clamped[28:18];
      out_data_q.arm_us      <= arm_hi_q ? ahp_pkg::PwHigh : ahp_pkg::PwLow;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: src/altitude_hold_pid_throttle.sv
`timescale 1ns / 1ps
// Altitude-hold throttle regulator with a clamped integral term.
// Channels: in_i takes items (cmd 0 restart, cmd 1 control step), out_o
// delivers one result per control step (throttle_us, arm_us), cfg_i writes
// the eight configuration registers by index; an index past the last
// register is accepted and dropped. cfg_i is always ready.
// A restart gives no result. An armed control step runs through the one
// shared 33x25 multiplier five times (ramp, integral gain by dt, by error,
// proportional, damping) plus a sum step and a clamp step. A disarmed step
// skips the multiplier. in_i is ready only while the sequencer is idle.
// The result sits in an output register; a new item is taken while it
// waits, and a step that finishes while out_o is stalled holds in its
// last cycle until the register frees up.
// Reset loads the register defaults and clears start time, setpoint,
// integral and the output valid.
`include "altitude_hold_pid_throttle_defines.svh"

module altitude_hold_pid_throttle (
  input  logic  clk_i,
  input  logic  rst_ni,
  ahp_in_if.sink     in_i,
  ahp_out_if.source  out_o,
  ahp_cfg_if.sink    cfg_i
);

  ahp_pkg::cfg_t cfg;

  // configuration registers
  assign cfg_i.ready = 1'b1;

  ahp_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_i.valid),
    .wr_index_i (cfg_i.index),
    .wr_data_i  (cfg_i.wdata),
    .cfg_o      (cfg)
  );

  // sequencer and datapath
  ahp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_i.valid),
    .in_data_i   (in_i.data),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_data_o  (out_o.data),
    .out_ready_i (out_o.ready)
  );

  // a control step keeps the block busy in the next cycle
  `AHP_ASSERT_NEXT(a_step_busy, in_i.valid && in_i.ready && (in_i.data.cmd == ahp_pkg::CmdStep), !in_i.ready)
  // a restart leaves in_i ready in the next cycle
  `AHP_ASSERT_NEXT(a_restart_quick, in_i.valid && in_i.ready && (in_i.data.cmd == ahp_pkg::CmdRestart), in_i.ready)
  // a new result only follows a busy cycle
  `AHP_ASSERT_NOW(a_result_after_busy, $rose(out_o.valid), $past(!in_i.ready))

endmodule
